### hdl/crfb_pkg.sv
// ----------------------------------------------------------------------------
// crfb_pkg
// Shared types and constants for the clipped rectangle fill and blit engine.
// ----------------------------------------------------------------------------
package crfb_pkg;

  localparam int COORD_BITS = 16;
  localparam int BYTES_PER_PIXEL = 4;
  localparam int SCR_BITS = 13;
  localparam int PITCH_BITS = 18;
  localparam int ADDR_BITS = 64;
  localparam int PIX_BITS = 32;
  localparam int CMP_BITS = (COORD_BITS > SCR_BITS) ? COORD_BITS : SCR_BITS;
  localparam int BPP_SHIFT = $clog2(BYTES_PER_PIXEL);

  // Input command kinds.
  localparam logic [2:0] KIND_SET   = 3'd0;
  localparam logic [2:0] KIND_GET   = 3'd1;
  localparam logic [2:0] KIND_FILL  = 3'd2;
  localparam logic [2:0] KIND_BLIT  = 3'd3;
  localparam logic [2:0] KIND_STEP  = 3'd4;

  // Result operations.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_ZERO  = 2'd2;
  localparam logic [1:0] OP_SKIP  = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_FB_BASE       = 3'd0;
  localparam logic [2:0] REG_ROW_PITCH     = 3'd1;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd2;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd3;
  localparam logic [2:0] REG_ENABLED       = 3'd4;

  typedef struct packed {
    logic [ADDR_BITS-1:0]  fb_base;
    logic [PITCH_BITS-1:0] row_pitch;
    logic [SCR_BITS-1:0]   screen_width;
    logic [SCR_BITS-1:0]   screen_height;
    logic                  enabled;
  } cfg_t;

  // One pixel access on its way to the clip and address stage.
  typedef struct packed {
    logic                       is_read;
    logic signed [COORD_BITS:0] px;
    logic signed [COORD_BITS:0] py;
    logic [PIX_BITS-1:0]        data;
    logic                       last;
  } pix_req_t;

endpackage

### hdl/crfb_cfg_regs.sv
// ----------------------------------------------------------------------------
// crfb_cfg_regs
// Configuration register file: base, pitch, screen size and enable.
// ----------------------------------------------------------------------------
module crfb_cfg_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [2:0]                cfg_index,
  input  logic [crfb_pkg::ADDR_BITS-1:0] cfg_data,
  output crfb_pkg::cfg_t            cfg
);
  import crfb_pkg::*;

  logic wr;

  assign cfg_ready = 1'b1;
  assign wr = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fb_base       <= '0;
      cfg.row_pitch     <= PITCH_BITS'(4096);
      cfg.screen_width  <= SCR_BITS'(1024);
      cfg.screen_height <= SCR_BITS'(768);
      cfg.enabled       <= 1'b0;
    end else if (wr) begin
      unique case (cfg_index)
        REG_FB_BASE:       cfg.fb_base       <= cfg_data;
        REG_ROW_PITCH:     cfg.row_pitch     <= cfg_data[PITCH_BITS-1:0];
        REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data[SCR_BITS-1:0];
        REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[SCR_BITS-1:0];
        REG_ENABLED:       cfg.enabled       <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

### hdl/crfb_walker.sv
// ----------------------------------------------------------------------------
// crfb_walker
// Command decode and rectangle walker. Holds the rectangle state and
// registers one pixel access per accepted command that produces a result.
// ----------------------------------------------------------------------------
module crfb_walker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        kind,
  input  logic signed [crfb_pkg::COORD_BITS-1:0] pos_x,
  input  logic signed [crfb_pkg::COORD_BITS-1:0] pos_y,
  input  logic signed [crfb_pkg::COORD_BITS-1:0] rect_w,
  input  logic signed [crfb_pkg::COORD_BITS-1:0] rect_h,
  input  logic [crfb_pkg::PIX_BITS-1:0]     pixel,
  input  logic                              enabled,
  output logic                              req_valid,
  output crfb_pkg::pix_req_t                req,
  input  logic                              req_ready
);
  import crfb_pkg::*;

  logic                         rect_active;
  logic                         rect_is_blit;
  logic signed [COORD_BITS-1:0] origin_x;
  logic signed [COORD_BITS-1:0] origin_y;
  logic [COORD_BITS-1:0]        span_w;
  logic [COORD_BITS-1:0]        span_h;
  logic [COORD_BITS-1:0]        cursor_col;
  logic [COORD_BITS-1:0]        cursor_row;
  logic [PIX_BITS-1:0]          fill_color;

  logic     accept;
  logic     has_result;
  logic     start_ok;
  logic     col_end;
  logic     fin;
  pix_req_t req_next;

  assign in_ready = !req_valid || req_ready;
  assign accept   = in_valid && in_ready;

  assign start_ok = enabled && (rect_w > 0) && (rect_h > 0);
  assign col_end  = (cursor_col == COORD_BITS'(span_w - 1'b1));
  assign fin      = col_end && (cursor_row == COORD_BITS'(span_h - 1'b1));

  always_comb begin
    has_result       = 1'b0;
    req_next.is_read = 1'b0;
    req_next.px      = (COORD_BITS+1)'(pos_x);
    req_next.py      = (COORD_BITS+1)'(pos_y);
    req_next.data    = pixel;
    req_next.last    = 1'b0;
    case (kind)
      KIND_SET: has_result = 1'b1;
      KIND_GET: begin
        has_result       = 1'b1;
        req_next.is_read = 1'b1;
        req_next.data    = '0;
      end
      KIND_STEP: begin
        has_result    = rect_active;
        // Origin plus offset gets one extra bit so that clipping sees the true sum.
        req_next.px   = (COORD_BITS+1)'(origin_x) + signed'({1'b0, cursor_col});
        req_next.py   = (COORD_BITS+1)'(origin_y) + signed'({1'b0, cursor_row});
        req_next.data = rect_is_blit ? pixel : fill_color;
        req_next.last = fin;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rect_active  <= 1'b0;
      rect_is_blit <= 1'b0;
      origin_x     <= '0;
      origin_y     <= '0;
      span_w       <= '0;
      span_h       <= '0;
      cursor_col   <= '0;
      cursor_row   <= '0;
      fill_color   <= '0;
    end else if (accept) begin
      case (kind) inside
        KIND_FILL, KIND_BLIT: begin
          rect_active <= start_ok;
          if (start_ok) begin
            rect_is_blit <= (kind == KIND_BLIT);
            origin_x     <= pos_x;
            origin_y     <= pos_y;
            span_w       <= rect_w;
            span_h       <= rect_h;
            cursor_col   <= '0;
            cursor_row   <= '0;
            fill_color   <= pixel;
          end
        end
        KIND_STEP: begin
          if (rect_active) begin
            if (fin) begin
              rect_active <= 1'b0;
              cursor_col  <= '0;
              cursor_row  <= '0;
            end else if (col_end) begin
              cursor_col <= '0;
              cursor_row <= cursor_row + 1'b1;
            end else begin
              cursor_col <= cursor_col + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= accept && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req <= req_next;
    end
  end

endmodule

### hdl/crfb_addr.sv
// ----------------------------------------------------------------------------
// crfb_addr
// Clip test and byte address generation, with the result register.
// ----------------------------------------------------------------------------
module crfb_addr (
  input  logic                              clk,
  input  logic                              rst,
  input  crfb_pkg::cfg_t                    cfg,
  input  logic                              req_valid,
  input  crfb_pkg::pix_req_t                req,
  output logic                              req_ready,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        op,
  output logic [crfb_pkg::ADDR_BITS-1:0]    address,
  output logic [crfb_pkg::PIX_BITS-1:0]     data,
  output logic                              last
);
  import crfb_pkg::*;

  logic [COORD_BITS-1:0]             x_mag;
  logic [COORD_BITS-1:0]             y_mag;
  logic                              vis;
  logic [SCR_BITS-1:0]               x_scr;
  logic [SCR_BITS-1:0]               y_scr;
  logic [SCR_BITS+PITCH_BITS-1:0]    row_off;
  logic [ADDR_BITS-1:0]              addr_next;
  logic                              load;

  assign x_mag = req.px[COORD_BITS-1:0];
  assign y_mag = req.py[COORD_BITS-1:0];

  assign vis = cfg.enabled && !req.px[COORD_BITS] && !req.py[COORD_BITS]
               && (CMP_BITS'(x_mag) < CMP_BITS'(cfg.screen_width))
               && (CMP_BITS'(y_mag) < CMP_BITS'(cfg.screen_height));

  // A visible position is below the screen size, so 13 bits carry it.
  assign x_scr   = SCR_BITS'(x_mag);
  assign y_scr   = SCR_BITS'(y_mag);
  assign row_off = (SCR_BITS+PITCH_BITS)'(y_scr) * (SCR_BITS+PITCH_BITS)'(cfg.row_pitch);
  assign addr_next = cfg.fb_base + ADDR_BITS'(row_off)
                     + (ADDR_BITS'(x_scr) << BPP_SHIFT);

  assign req_ready = !out_valid || out_ready;
  assign load      = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req_ready) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last <= req.last;
      if (vis) begin
        op      <= req.is_read ? OP_READ : OP_WRITE;
        address <= addr_next;
        data    <= req.data;
      end else begin
        op      <= req.is_read ? OP_ZERO : OP_SKIP;
        address <= '0;
        data    <= '0;
      end
    end
  end

endmodule

### hdl/clipped_rect_fill_blit_engine.sv
// ----------------------------------------------------------------------------
// clipped_rect_fill_blit_engine
// Framebuffer access engine: single pixel writes and reads, rectangle fill
// and blit walked one position per step command, with screen clipping.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+--------------------------------
//   in      | in        | in_valid / in_ready   | kind pos_x pos_y rect_w rect_h pixel
//   out     | out       | out_valid / out_ready | op address data last
//   cfg     | in        | cfg_valid / cfg_ready | cfg_index cfg_data
//
// A command passes from transfer to result through the decode and rectangle
// walker register, then the clip and address register, where the row times
// pitch multiply sits. One command is taken every cycle while the output is not stalled.
// Reset is synchronous and leaves the engine disabled with no active rectangle.
// A stalled output holds the result register; the walker register keeps taking
// a command as long as it empties into the result register in the same cycle.
// ----------------------------------------------------------------------------
module clipped_rect_fill_blit_engine (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        kind,
  input  logic signed [crfb_pkg::COORD_BITS-1:0] pos_x,
  input  logic signed [crfb_pkg::COORD_BITS-1:0] pos_y,
  input  logic signed [crfb_pkg::COORD_BITS-1:0] rect_w,
  input  logic signed [crfb_pkg::COORD_BITS-1:0] rect_h,
  input  logic [crfb_pkg::PIX_BITS-1:0]     pixel,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        op,
  output logic [crfb_pkg::ADDR_BITS-1:0]    address,
  output logic [crfb_pkg::PIX_BITS-1:0]     data,
  output logic                              last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [2:0]                        cfg_index,
  input  logic [crfb_pkg::ADDR_BITS-1:0]    cfg_data
);
  import crfb_pkg::*;

  cfg_t     cfg;
  pix_req_t req;
  logic     req_valid;
  logic     req_ready;

  crfb_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  crfb_walker u_walker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .rect_w    (rect_w),
    .rect_h    (rect_h),
    .pixel     (pixel),
    .enabled   (cfg.enabled),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready)
  );

  crfb_addr u_addr (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .op        (op),
    .address   (address),
    .data      (data),
    .last      (last)
  );

endmodule
